// ===== rtl/cdaxpy_pkg.sv =====
// Shared constants and types for the complex dual axpy block.
`default_nettype none

package cdaxpy_pkg;

   // Default element width (signed fixed point, width-1 fraction bits)
   localparam int DATA_WIDTH_DEF = 16;

   // Register port geometry: six 32-bit registers at byte offsets 4*i
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_ALPHA_X_RE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ALPHA_X_IM = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ALPHA_Y_RE = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ALPHA_Y_IM = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CONJ_X     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CONJ_Y     = 3'd5;

   // Partial product slots
   localparam int NPROD      = 8;
   localparam int PROD_AXR_XR = 0;   // real part
   localparam int PROD_AXI_XI = 1;
   localparam int PROD_AYR_YR = 2;
   localparam int PROD_AYI_YI = 3;
   localparam int PROD_AXR_XI = 4;   // imaginary part
   localparam int PROD_AXI_XR = 5;
   localparam int PROD_AYR_YI = 6;
   localparam int PROD_AYI_YR = 7;

   typedef struct packed {
      logic conj_y;
      logic conj_x;
   } conj_type;

endpackage

`default_nettype wire

// ===== rtl/cdaxpy_csr.sv =====
// Register file for scalars and conjugate flags, APB-style access.
`default_nettype none

module cdaxpy_csr
   import cdaxpy_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic      [CSR_DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready,
   output logic signed [DATA_WIDTH-1:0]      alpha_x_re,
   output logic signed [DATA_WIDTH-1:0]      alpha_x_im,
   output logic signed [DATA_WIDTH-1:0]      alpha_y_re,
   output logic signed [DATA_WIDTH-1:0]      alpha_y_im,
   output conj_type                          conj
);

   logic signed [DATA_WIDTH-1:0] axr_ff, axi_ff, ayr_ff, ayi_ff;
   conj_type                     conj_ff;
   logic                         wr_en;
   logic [REG_IDX_W-1:0]         idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         axr_ff  <= '0;
         axi_ff  <= '0;
         ayr_ff  <= '0;
         ayi_ff  <= '0;
         conj_ff <= '0;
      end else if (wr_en) begin
         unique case (idx)
            REG_ALPHA_X_RE: axr_ff <= csr_pwdata[DATA_WIDTH-1:0];
            REG_ALPHA_X_IM: axi_ff <= csr_pwdata[DATA_WIDTH-1:0];
            REG_ALPHA_Y_RE: ayr_ff <= csr_pwdata[DATA_WIDTH-1:0];
            REG_ALPHA_Y_IM: ayi_ff <= csr_pwdata[DATA_WIDTH-1:0];
            REG_CONJ_X:     conj_ff.conj_x <= csr_pwdata[0];
            REG_CONJ_Y:     conj_ff.conj_y <= csr_pwdata[0];
            default:        ;  // unmapped, ignored
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_ALPHA_X_RE: csr_prdata[DATA_WIDTH-1:0] = axr_ff;
         REG_ALPHA_X_IM: csr_prdata[DATA_WIDTH-1:0] = axi_ff;
         REG_ALPHA_Y_RE: csr_prdata[DATA_WIDTH-1:0] = ayr_ff;
         REG_ALPHA_Y_IM: csr_prdata[DATA_WIDTH-1:0] = ayi_ff;
         REG_CONJ_X:     csr_prdata[0] = conj_ff.conj_x;
         REG_CONJ_Y:     csr_prdata[0] = conj_ff.conj_y;
         default:        csr_prdata = '0;
      endcase
   end

   assign alpha_x_re = axr_ff;
   assign alpha_x_im = axi_ff;
   assign alpha_y_re = ayr_ff;
   assign alpha_y_im = ayi_ff;
   assign conj       = conj_ff;

endmodule

`default_nettype wire

// ===== rtl/cdaxpy_mul.sv =====
// Stage 1: the eight real partial products, registered.
`default_nettype none

module cdaxpy_mul
   import cdaxpy_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int PW = 2*DATA_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [DATA_WIDTH-1:0] x_re,
   input  wire logic signed [DATA_WIDTH-1:0] x_im,
   input  wire logic signed [DATA_WIDTH-1:0] y_re,
   input  wire logic signed [DATA_WIDTH-1:0] y_im,
   input  wire logic signed [DATA_WIDTH-1:0] z_re,
   input  wire logic signed [DATA_WIDTH-1:0] z_im,
   input  wire logic                         in_last,
   input  wire logic signed [DATA_WIDTH-1:0] alpha_x_re,
   input  wire logic signed [DATA_WIDTH-1:0] alpha_x_im,
   input  wire logic signed [DATA_WIDTH-1:0] alpha_y_re,
   input  wire logic signed [DATA_WIDTH-1:0] alpha_y_im,
   input  wire conj_type                     conj,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [PW-1:0]              prod [NPROD],
   output logic signed [DATA_WIDTH-1:0]      out_z_re,
   output logic signed [DATA_WIDTH-1:0]      out_z_im,
   output logic                              out_last,
   output conj_type                          out_conj
);

   logic                         valid_ff;
   logic signed [PW-1:0]         prod_ff [NPROD];
   logic signed [PW-1:0]         prod_in [NPROD];
   logic signed [DATA_WIDTH-1:0] zr_ff, zi_ff;
   logic                         last_ff;
   conj_type                     conj_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      prod_in[PROD_AXR_XR] = alpha_x_re * x_re;
      prod_in[PROD_AXI_XI] = alpha_x_im * x_im;
      prod_in[PROD_AYR_YR] = alpha_y_re * y_re;
      prod_in[PROD_AYI_YI] = alpha_y_im * y_im;
      prod_in[PROD_AXR_XI] = alpha_x_re * x_im;
      prod_in[PROD_AXI_XR] = alpha_x_im * x_re;
      prod_in[PROD_AYR_YI] = alpha_y_re * y_im;
      prod_in[PROD_AYI_YR] = alpha_y_im * y_re;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         prod_ff <= prod_in;
         zr_ff   <= z_re;
         zi_ff   <= z_im;
         last_ff <= in_last;
         conj_ff <= conj;
      end
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;
   assign out_z_re  = zr_ff;
   assign out_z_im  = zi_ff;
   assign out_last  = last_ff;
   assign out_conj  = conj_ff;

endmodule

`default_nettype wire

// ===== rtl/cdaxpy_add.sv =====
// Stages 2 and 3: signed pair sums, then full sum with aligned z and rounding half.
`default_nettype none

module cdaxpy_add
   import cdaxpy_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int PW = 2*DATA_WIDTH,
   localparam int SW = 2*DATA_WIDTH + 3
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [PW-1:0]         prod [NPROD],
   input  wire logic signed [DATA_WIDTH-1:0] z_re,
   input  wire logic signed [DATA_WIDTH-1:0] z_im,
   input  wire logic                         in_last,
   input  wire conj_type                     conj,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [SW-1:0]              sum_re,
   output logic signed [SW-1:0]              sum_im,
   output logic                              out_last
);

   // stage 2
   logic                         v2_ff;
   logic                         rdy2;
   logic signed [PW:0]           ext [NPROD];
   logic signed [PW:0]           re_a_in, re_b_in, im_a_in, im_b_in;
   logic signed [PW:0]           re_a_ff, re_b_ff, im_a_ff, im_b_ff;
   logic signed [DATA_WIDTH-1:0] zr2_ff, zi2_ff;
   logic                         last2_ff;

   // stage 3
   logic                         v3_ff;
   logic                         rdy3;
   logic signed [PW-2:0]         zr_al, zi_al;
   logic signed [SW-1:0]         sre_in, sim_in, sre_ff, sim_ff;
   logic                         last3_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;

   // Conjugation flips the sign of every term that carries the operand's
   // imaginary part; the product itself is formed on the raw value.
   always_comb begin
      for (int i = 0; i < NPROD; i++) begin
         ext[i] = (PW+1)'(prod[i]);
      end
      re_a_in = ext[PROD_AXR_XR] + (conj.conj_x ? ext[PROD_AXI_XI] : -ext[PROD_AXI_XI]);
      re_b_in = ext[PROD_AYR_YR] + (conj.conj_y ? ext[PROD_AYI_YI] : -ext[PROD_AYI_YI]);
      im_a_in = (conj.conj_x ? -ext[PROD_AXR_XI] : ext[PROD_AXR_XI]) + ext[PROD_AXI_XR];
      im_b_in = (conj.conj_y ? -ext[PROD_AYR_YI] : ext[PROD_AYR_YI]) + ext[PROD_AYI_YR];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         re_a_ff  <= re_a_in;
         re_b_ff  <= re_b_in;
         im_a_ff  <= im_a_in;
         im_b_ff  <= im_b_in;
         zr2_ff   <= z_re;
         zi2_ff   <= z_im;
         last2_ff <= in_last;
      end
   end

   // z aligned to the product scale with the rounding half in the low bits
   assign zr_al = $signed({zr2_ff, 1'b1, {(DATA_WIDTH-2){1'b0}}});
   assign zi_al = $signed({zi2_ff, 1'b1, {(DATA_WIDTH-2){1'b0}}});

   always_comb begin
      sre_in = SW'(re_a_ff) + SW'(re_b_ff) + SW'(zr_al);
      sim_in = SW'(im_a_ff) + SW'(im_b_ff) + SW'(zi_al);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         sre_ff   <= sre_in;
         sim_ff   <= sim_in;
         last3_ff <= last2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign sum_re    = sre_ff;
   assign sum_im    = sim_ff;
   assign out_last  = last3_ff;

endmodule

`default_nettype wire

// ===== rtl/cdaxpy_rnd.sv =====
// Stage 4: drop fraction bits, saturate both parts, hold the result beat.
`default_nettype none

module cdaxpy_rnd
   import cdaxpy_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int SW = 2*DATA_WIDTH + 3,
   localparam int FB = DATA_WIDTH - 1,
   localparam int HW = SW - FB
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [SW-1:0]         sum_re,
   input  wire logic signed [SW-1:0]         sum_im,
   input  wire logic                         in_last,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [DATA_WIDTH-1:0]      out_re,
   output logic signed [DATA_WIDTH-1:0]      out_im,
   output logic                              out_sat,
   output logic                              out_last
);

   localparam logic signed [HW-1:0] HI_MAX = $signed({{(HW-FB){1'b0}}, {FB{1'b1}}});
   localparam logic signed [HW-1:0] HI_MIN = $signed({{(HW-FB){1'b1}}, {FB{1'b0}}});
   localparam logic [DATA_WIDTH-1:0] Q_MAX = {1'b0, {FB{1'b1}}};
   localparam logic [DATA_WIDTH-1:0] Q_MIN = {1'b1, {FB{1'b0}}};

   logic                         valid_ff;
   logic signed [HW-1:0]         hre, him;
   logic                         re_hi, re_lo, im_hi, im_lo;
   logic signed [DATA_WIDTH-1:0] re_in, im_in, re_ff, im_ff;
   logic                         sat_in, sat_ff, last_ff;

   assign in_ready = !valid_ff || out_ready;

   // floor shift; the half was already added upstream
   assign hre = $signed(sum_re[SW-1:FB]);
   assign him = $signed(sum_im[SW-1:FB]);

   always_comb begin
      re_hi  = hre > HI_MAX;
      re_lo  = hre < HI_MIN;
      im_hi  = him > HI_MAX;
      im_lo  = him < HI_MIN;
      re_in  = re_hi ? Q_MAX : (re_lo ? Q_MIN : hre[DATA_WIDTH-1:0]);
      im_in  = im_hi ? Q_MAX : (im_lo ? Q_MIN : him[DATA_WIDTH-1:0]);
      sat_in = re_hi || re_lo || im_hi || im_lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         re_ff   <= re_in;
         im_ff   <= im_in;
         sat_ff  <= sat_in;
         last_ff <= in_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;
   assign out_sat   = sat_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/complex_dual_axpy.sv =====
// Top level: streaming complex update z' = z + ax*cx(x) + ay*cy(y), Q1.15 fixed point.
//
// Usage notes:
//  - req_* stream: one beat carries one complex element of x, y and z;
//    req_tlast marks the last element of a vector and is copied to rsp_tlast.
//  - rsp_* stream: one beat per request beat, same order; tdata holds the
//    rounded, saturated z'; tuser is set when either part was clipped.
//  - csr_* port: APB-style, registers at byte offsets 0x00..0x14
//    (alpha_x re/im, alpha_y re/im, conj_x, conj_y). Write only while idle.
//  - Pipeline: multiply, pair add, final add with round half, saturate.
//    Sustains one beat per cycle while rsp_tready stays high, set by the four
//    register stages each taking a new beat.
//  - Each stage holds its own valid bit and takes a new beat whenever it is
//    empty or its successor moves, so bubbles close up and a stalled result
//    does not stop accepting until all four stages are full.
//  - rsp_tready low: the result beat holds steady; req_tready drops once the
//    pipe is full. No beat is lost or repeated.
//  - Reset clears all valid bits and sets every config register to zero.
`default_nettype none

module complex_dual_axpy
   import cdaxpy_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int REQ_W = ((6*DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((2*DATA_WIDTH + 7) / 8) * 8,
   localparam int PW    = 2*DATA_WIDTH,
   localparam int SW    = 2*DATA_WIDTH + 3
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // tdata: x_re, x_im, y_re, y_im, z_re, z_im (lowest first), zero pad
   input  wire logic [REQ_W-1:0]       req_tdata,
   input  wire logic                   req_tlast,
   // response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // tdata: out_re, out_im (lowest first), zero pad
   output logic [RSP_W-1:0]            rsp_tdata,
   // tuser: saturated
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   // register port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int W = DATA_WIDTH;

   logic signed [W-1:0]  x_re, x_im, y_re, y_im, z_re, z_im;
   logic signed [W-1:0]  axr, axi, ayr, ayi;
   conj_type             conj;

   logic                 m_valid, m_ready, m_last;
   logic signed [PW-1:0] m_prod [NPROD];
   logic signed [W-1:0]  m_zr, m_zi;
   conj_type             m_conj;

   logic                 a_valid, a_ready, a_last;
   logic signed [SW-1:0] a_sre, a_sim;

   logic signed [W-1:0]  out_re, out_im;

   // unpack request fields
   assign x_re = $signed(req_tdata[0*W +: W]);
   assign x_im = $signed(req_tdata[1*W +: W]);
   assign y_re = $signed(req_tdata[2*W +: W]);
   assign y_im = $signed(req_tdata[3*W +: W]);
   assign z_re = $signed(req_tdata[4*W +: W]);
   assign z_im = $signed(req_tdata[5*W +: W]);

   cdaxpy_csr #(.DATA_WIDTH(DATA_WIDTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .alpha_x_re  (axr),
      .alpha_x_im  (axi),
      .alpha_y_re  (ayr),
      .alpha_y_im  (ayi),
      .conj        (conj)
   );

   // stage 1: products
   cdaxpy_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .x_re       (x_re),
      .x_im       (x_im),
      .y_re       (y_re),
      .y_im       (y_im),
      .z_re       (z_re),
      .z_im       (z_im),
      .in_last    (req_tlast),
      .alpha_x_re (axr),
      .alpha_x_im (axi),
      .alpha_y_re (ayr),
      .alpha_y_im (ayi),
      .conj       (conj),
      .out_valid  (m_valid),
      .out_ready  (m_ready),
      .prod       (m_prod),
      .out_z_re   (m_zr),
      .out_z_im   (m_zi),
      .out_last   (m_last),
      .out_conj   (m_conj)
   );

   // stages 2-3: sums
   cdaxpy_add #(.DATA_WIDTH(DATA_WIDTH)) u_add (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .prod      (m_prod),
      .z_re      (m_zr),
      .z_im      (m_zi),
      .in_last   (m_last),
      .conj      (m_conj),
      .out_valid (a_valid),
      .out_ready (a_ready),
      .sum_re    (a_sre),
      .sum_im    (a_sim),
      .out_last  (a_last)
   );

   // stage 4: round down and saturate, output register
   cdaxpy_rnd #(.DATA_WIDTH(DATA_WIDTH)) u_rnd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .in_ready  (a_ready),
      .sum_re    (a_sre),
      .sum_im    (a_sim),
      .in_last   (a_last),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_re    (out_re),
      .out_im    (out_im),
      .out_sat   (rsp_tuser),
      .out_last  (rsp_tlast)
   );

   always_comb begin
      rsp_tdata           = '0;
      rsp_tdata[2*W-1:0]  = {out_im, out_re};
   end

endmodule

`default_nettype wire

// ===== verif/complex_dual_axpy_test.sv =====
// Self-checking testbench for complex_dual_axpy: streams elements, predicts each updated z.
module complex_dual_axpy_test
   import cdaxpy_pkg::*;
;
   localparam int DW       = DATA_WIDTH_DEF;
   localparam int FRAC     = DW - 1;
   localparam int REQ_W    = ((6*DW + 7) / 8) * 8;
   localparam int RSP_W    = ((2*DW + 7) / 8) * 8;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int IDLE_PCT      = 13;     // chance in 100 that a side idles
   localparam int PIPE_SLACK    = 8;      // pipe is 4 deep; a bit of margin
   localparam int PHASES        = 6;
   localparam int BEATS_PER_PHASE = 75;
   localparam int REPORT_LIMIT  = 10;
   localparam int TIMEOUT_UNITS = 2_000_000;

   localparam logic signed [DW-1:0] MAX_Q = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MIN_Q = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] HALF_Q = {2'b01, {(DW-2){1'b0}}};   // 0.5

   // Indexes past the last register; writes there must be dropped
   localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef struct {
      logic signed [DW-1:0] x_re, x_im, y_re, y_im, z_re, z_im;
      logic                 last;
   } element_type;

   typedef struct {
      logic signed [DW-1:0] re, im;
      logic                 sat;
      logic                 last;
   } zout_type;

   // ---------------------------------------------------------------- DUT ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_tvalid = 1'b0;
   logic               req_tready;
   // tdata: x_re, x_im, y_re, y_im, z_re, z_im (lowest first)
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               req_tlast  = 1'b0;

   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   // tdata: out_re, out_im (lowest first)
   logic [RSP_W-1:0]   rsp_tdata;
   // tuser: saturated
   logic               rsp_tuser;
   logic               rsp_tlast;

   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   complex_dual_axpy #(.DATA_WIDTH(DW)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------- shared state
   // Shadow copy of the register file, updated on each completed write
   logic signed [DW-1:0] ax_re, ax_im, ay_re, ay_im;
   conj_type             conj_cfg;

   zout_type pending_z[$];  // updated z values still owed by the block, oldest first
   int    error_count = 0;
   bit    steady_run  = 1'b0; // when set, neither side idles

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------- prediction
   // Round half up from Q5.30 to Q1.15, then clip; sat is sticky across both parts.
   function automatic logic signed [DW-1:0] round_clip(input longint acc, inout logic sat);
      longint v;
      v = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (v > longint'(MAX_Q)) begin
         sat = 1'b1;
         v   = longint'(MAX_Q);
      end
      if (v < longint'(MIN_Q)) begin
         sat = 1'b1;
         v   = longint'(MIN_Q);
      end
      return DW'(v);
   endfunction

   // z' = z + ax*cx(x) + ay*cy(y), summed exactly before a single rounding
   function automatic zout_type predict_update(input element_type e);
      longint xr, xi, yr, yi, axr, axi, ayr, ayi, acc_re, acc_im;
      zout_type r;
      logic   sat;
      xr  = e.x_re;  xi  = e.x_im;
      yr  = e.y_re;  yi  = e.y_im;
      axr = ax_re;   axi = ax_im;
      ayr = ay_re;   ayi = ay_im;
      // conjugate flips the imaginary part; -MIN_Q needs the wide type
      if (conj_cfg.conj_x) xi = -xi;
      if (conj_cfg.conj_y) yi = -yi;
      acc_re = (longint'(e.z_re) <<< FRAC) + axr*xr - axi*xi + ayr*yr - ayi*yi;
      acc_im = (longint'(e.z_im) <<< FRAC) + axr*xi + axi*xr + ayr*yi + ayi*yr;
      sat    = 1'b0;
      r.re   = round_clip(acc_re, sat);
      r.im   = round_clip(acc_im, sat);
      r.sat  = sat;
      r.last = e.last;
      return r;
   endfunction

   // Register file as seen by software: only the low bits of each write survive
   function automatic void apply_csr(input logic [REG_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_ALPHA_X_RE: ax_re = value[DW-1:0];
         REG_ALPHA_X_IM: ax_im = value[DW-1:0];
         REG_ALPHA_Y_RE: ay_re = value[DW-1:0];
         REG_ALPHA_Y_IM: ay_im = value[DW-1:0];
         REG_CONJ_X:     conj_cfg.conj_x = value[0];
         REG_CONJ_Y:     conj_cfg.conj_y = value[0];
         default: ;      // spare index, dropped
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   // Biased toward full scale, zero and tiny values so carries and clipping get hit
   function automatic logic signed [DW-1:0] pick_q15();
      int s;
      s = $urandom_range(0, 9);
      case (s)
         0: return MIN_Q;
         1: return MAX_Q;
         2: return '0;
         3: return DW'(int'($urandom_range(0, 6)) - 3);
         default: return DW'($urandom());
      endcase
   endfunction

   function automatic element_type random_element();
      element_type e;
      e.x_re = pick_q15();
      e.x_im = pick_q15();
      e.y_re = pick_q15();
      e.y_im = pick_q15();
      e.z_re = pick_q15();
      e.z_im = pick_q15();
      e.last = ($urandom_range(0, 7) == 0);
      return e;
   endfunction

   function automatic element_type make_element(input logic signed [DW-1:0] xr, xi, yr, yi,
                                                zr, zi, input logic last);
      element_type e;
      e.x_re = xr;  e.x_im = xi;
      e.y_re = yr;  e.y_im = yi;
      e.z_re = zr;  e.z_im = zi;
      e.last = last;
      return e;
   endfunction

   // APB write: setup, access, done. Called and returns at a rising edge, leaves
   // one quiet cycle so back-to-back writes never touch psel twice in one step.
   task automatic write_csr(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      apply_csr(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Full scalar pair plus flags, with junk in the unused upper bits
   task automatic load_settings(input logic signed [DW-1:0] axr, axi, ayr, ayi,
                                input logic cx, cy);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom();
      write_csr(REG_ALPHA_X_RE, {junk[CSR_DATA_W-1:DW], axr});
      junk = $urandom();
      write_csr(REG_ALPHA_X_IM, {junk[CSR_DATA_W-1:DW], axi});
      junk = $urandom();
      write_csr(REG_ALPHA_Y_RE, {junk[CSR_DATA_W-1:DW], ayr});
      junk = $urandom();
      write_csr(REG_ALPHA_Y_IM, {junk[CSR_DATA_W-1:DW], ayi});
      junk = $urandom();
      write_csr(REG_CONJ_X, {junk[CSR_DATA_W-1:1], cx});
      junk = $urandom();
      write_csr(REG_CONJ_Y, {junk[CSR_DATA_W-1:1], cy});
   endtask

   // One request beat. Handshake is judged at the falling edge where both
   // sides are settled; the beat lands on the following rising edge.
   task automatic send_element(input element_type e);
      while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {e.z_im, e.z_re, e.y_im, e.y_re, e.x_im, e.x_re};
      req_tlast  <= e.last;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      pending_z.push_back(predict_update(e));
   endtask

   // Stop sending and let every owed beat come back before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_z.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests
   // Out of reset both scalars are zero: z must pass through untouched
   task automatic test_zero_scalars();
      send_element(make_element(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MAX_Q, MIN_Q, 1'b0));
      send_element(make_element(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MIN_Q, MAX_Q, 1'b0));
      send_element(make_element(MIN_Q, MAX_Q, MAX_Q, MIN_Q, '0, -1, 1'b0));
      send_element(make_element(1, -1, 1, -1, 1, -1, 1'b1));
      drain();
   endtask

   // Upper bits of each write are junk and must be dropped; spare indexes ignored
   task automatic test_register_widths();
      write_csr(REG_ALPHA_X_RE, 32'hA5A5_8000);   // keeps -1.0
      write_csr(REG_ALPHA_X_IM, 32'h0001_7FFF);
      write_csr(REG_ALPHA_Y_RE, 32'hFFFF_0001);
      write_csr(REG_ALPHA_Y_IM, 32'h8000_FFFF);
      write_csr(REG_CONJ_X,     32'hFFFF_FFFE);   // bit 0 clear
      write_csr(REG_CONJ_Y,     32'h0000_0003);   // bit 0 set
      write_csr(REG_SPARE_6,    $urandom());
      write_csr(REG_SPARE_7,    $urandom());
      send_element(make_element(HALF_Q, -HALF_Q, 100, -100, 7, -7, 1'b0));
      send_element(make_element(MAX_Q, MIN_Q, MIN_Q, MAX_Q, 0, 0, 1'b0));
      send_element(random_element());
      drain();
   endtask

   // ax = 0.5 gives products sitting exactly on the half-LSB tie
   task automatic test_rounding();
      load_settings(HALF_Q, '0, '0, '0, 1'b0, 1'b0);
      send_element(make_element(1, -1, MAX_Q, MIN_Q, 0, 0, 1'b0));     // +0.5 up, -0.5 to 0
      send_element(make_element(3, -3, 0, 0, -1, 1, 1'b0));
      send_element(make_element(-5, 5, 0, 0, MAX_Q, MIN_Q, 1'b1));
      drain();
   endtask

   // Full-scale scalars and operands: clipping on both sides, mixed conjugates
   task automatic test_full_scale();
      load_settings(MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1'b1, 1'b0);
      send_element(make_element(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1'b0));
      send_element(make_element(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b0));
      send_element(make_element(MIN_Q, MAX_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, 1'b0));
      send_element(make_element(0, 0, 0, 0, MIN_Q, MAX_Q, 1'b1));
      drain();
      load_settings(MAX_Q, MAX_Q, MAX_Q, MIN_Q, 1'b0, 1'b1);
      send_element(make_element(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1'b0));
      send_element(make_element(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b0));
      send_element(make_element(MAX_Q, MIN_Q, MIN_Q, MAX_Q, 0, -1, 1'b0));
      send_element(make_element(1, 1, -1, -1, MIN_Q, MAX_Q, 1'b1));
      drain();
   endtask

   // Random scalars per phase, random elements; one phase runs with no idling
   task automatic test_random_phases();
      logic cx, cy;
      for (int p = 0; p < PHASES; p++) begin
         cx = 1'($urandom_range(0, 1));
         cy = 1'($urandom_range(0, 1));
         load_settings(pick_q15(), pick_q15(), pick_q15(), pick_q15(), cx, cy);
         steady_run = (p == 1);
         for (int i = 0; i < BEATS_PER_PHASE; i++) send_element(random_element());
         drain();
      end
      steady_run = 1'b0;
   endtask

   // ---------------------------------------------------------------- result side
   // Random back-pressure, none while a steady phase runs
   always @(posedge clock) begin
      rsp_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Compare each result beat at the falling edge before it is taken
   always @(negedge clock) begin
      zout_type             want;
      logic signed [DW-1:0] got_re, got_im;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_re = rsp_tdata[DW-1:0];
         got_im = rsp_tdata[2*DW-1:DW];
         if (pending_z.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("ERROR: unexpected result beat re=%0d im=%0d sat=%b last=%b",
                        got_re, got_im, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_z.pop_front();
            if (got_re !== want.re || got_im !== want.im ||
                rsp_tuser !== want.sat || rsp_tlast !== want.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("ERROR: z mismatch exp re=%0d im=%0d sat=%b last=%b,",
                           want.re, want.im, want.sat, want.last);
                  $display("       got re=%0d im=%0d sat=%b last=%b",
                           got_re, got_im, rsp_tuser, rsp_tlast);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      // shadow matches the block's reset values
      ax_re = '0;
      ax_im = '0;
      ay_re = '0;
      ay_im = '0;
      conj_cfg = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_scalars();
      test_register_widths();
      test_rounding();
      test_full_scale();
      test_random_phases();

      drain();
      if (pending_z.size() != 0) error_count++;
      if (error_count == 0)
         $display("complex_dual_axpy_test passed");
      else
         $display("complex_dual_axpy_test failed");
      $finish;
   end

   // Hang guard: far beyond the slowest legal run
   initial begin
      #(TIMEOUT_UNITS);
      $display("complex_dual_axpy_test failed");
      $finish;
   end

endmodule
